// ----- hw/rtl/ptpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpd_pkg: shared types and constants of the perspective divide unit
// Holds the channel payload structs, the register map and the format limits.
// ----------------------------------------------------------------------------
`default_nettype none
package ptpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int COORD_W       = 32;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_z;
    logic                      w_zero;
    logic                      clipped;
  } out_item_t;

endpackage : ptpd_pkg
`default_nettype wire

// ----- hw/rtl/ptpd_front.sv -----
// ----------------------------------------------------------------------------
// ptpd_front: matrix registers and column sums
// Holds the matrix, forms the four exact column sums in a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module ptpd_front #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int SUM_W     = 67
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ptpd_pkg::IDX_W-1:0]   cfg_idx,
  input  wire logic [ptpd_pkg::REG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  input  wire ptpd_pkg::in_item_t           in_data,
  input  wire logic                         adv,
  output logic                              sum_valid,
  output logic signed [4*SUM_W-1:0]         sums
);
  localparam int PW = 2 * ptpd_pkg::COORD_W;

  logic [ptpd_pkg::REG_W-1:0] regs_r [ptpd_pkg::NUM_REGS];
  logic signed [PW-1:0]       prod_r [12];
  logic signed [SUM_W-1:0]    bias_r [4];
  logic                       v1_r;
  logic signed [SUM_W-1:0]    sum_r  [4];
  logic                       v2_r;
  logic signed [31:0]         ent [4][4];
  logic signed [31:0]         pt  [3];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = (c % 2 == 1) ? regs_r[r*2 + c/2][63:32] : regs_r[r*2 + c/2][31:0];
      end
    end
    pt[0] = in_data.point_x;
    pt[1] = in_data.point_y;
    pt[2] = in_data.point_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[ptpd_pkg::REG_ROW0_C01] <= ptpd_pkg::REG_W'(1) << FRAC_BITS;
      regs_r[ptpd_pkg::REG_ROW0_C23] <= '0;
      regs_r[ptpd_pkg::REG_ROW1_C01] <= ptpd_pkg::REG_W'(1) << (FRAC_BITS + 32);
      regs_r[ptpd_pkg::REG_ROW1_C23] <= '0;
      regs_r[ptpd_pkg::REG_ROW2_C01] <= '0;
      regs_r[ptpd_pkg::REG_ROW2_C23] <= ptpd_pkg::REG_W'(1) << FRAC_BITS;
      regs_r[ptpd_pkg::REG_ROW3_C01] <= '0;
      regs_r[ptpd_pkg::REG_ROW3_C23] <= ptpd_pkg::REG_W'(1) << (FRAC_BITS + 32);
    end else if (cfg_we) begin
      regs_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Stage 1: twelve products, stage 2: sums. Both advance together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r*4+c] <= PW'(pt[r]) * PW'(ent[r][c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        bias_r[c] <= SUM_W'(ent[3][c]) <<< FRAC_BITS;
        sum_r[c]  <= bias_r[c] + SUM_W'(prod_r[c]) + SUM_W'(prod_r[4+c])
                     + SUM_W'(prod_r[8+c]);
      end
    end
  end

  assign sum_valid = v2_r;
  assign sums      = {sum_r[3], sum_r[2], sum_r[1], sum_r[0]};

endmodule : ptpd_front
`default_nettype wire

// ----- hw/rtl/ptpd_queue.sv -----
// ----------------------------------------------------------------------------
// ptpd_queue: short FIFO between front and back
// Holds column sums until the divider pipeline takes them.
// ----------------------------------------------------------------------------
`default_nettype none
module ptpd_queue #(
  parameter int W     = 268,
  parameter int DEPTH = ptpd_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd_en,
  output logic              rd_valid,
  output logic [W-1:0]      rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + AW'(1);
      if (rd_en) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + $bits(cnt_r)'(wr_en) - $bits(cnt_r)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign count    = cnt_r;
endmodule : ptpd_queue
`default_nettype wire

// ----- hw/rtl/ptpd_div_stage.sv -----
// ----------------------------------------------------------------------------
// ptpd_div_stage: four restoring divide steps for three lanes
// Shift in one numerator bit per step, compare and subtract against |w|.
// ----------------------------------------------------------------------------
`default_nettype none
module ptpd_div_stage #(
  parameter int NW    = 83,
  parameter int DW    = 67,
  parameter int STEPS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          v_in,
  input  wire logic [NW-1:0] num_in [3],
  input  wire logic [DW:0]   rem_in [3],
  input  wire logic [DW-1:0] den_in,
  input  wire logic [2:0]    neg_in,
  input  wire logic          wz_in,
  output logic               v_out,
  output logic [NW-1:0]      num_out [3],
  output logic [DW:0]        rem_out [3],
  output logic [DW-1:0]      den_out,
  output logic [2:0]         neg_out,
  output logic               wz_out
);
  logic [NW-1:0] n_c [3];
  logic [DW:0]   r_c [3];
  logic [DW:0]   t;

  always_comb begin
    t = '0;
    for (int l = 0; l < 3; l++) begin
      n_c[l] = num_in[l];
      r_c[l] = rem_in[l];
      for (int s = 0; s < STEPS; s++) begin
        t = {r_c[l][DW-1:0], n_c[l][NW-1]};
        n_c[l] = n_c[l] << 1;
        if (t >= {1'b0, den_in}) begin
          r_c[l] = t - {1'b0, den_in};
          n_c[l][0] = 1'b1;
        end else begin
          r_c[l] = t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_out <= 1'b0;
    else if (adv) v_out <= v_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_out <= n_c;
      rem_out <= r_c;
      den_out <= den_in;
      neg_out <= neg_in;
      wz_out  <= wz_in;
    end
  end
endmodule : ptpd_div_stage
`default_nettype wire

// ----- hw/rtl/ptpd_back.sv -----
// ----------------------------------------------------------------------------
// ptpd_back: pipelined perspective divide
// Takes absolute values, runs the divide chain, signs, saturates, zeroes if w=0.
// ----------------------------------------------------------------------------
`default_nettype none
module ptpd_back #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int SUM_W     = 67,
  parameter int STEPS     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 v_in,
  input  wire logic [4*SUM_W-1:0]   sums,
  output logic                      v_out,
  output ptpd_pkg::out_item_t       res
);
  localparam int NW   = SUM_W + FRAC_BITS;
  localparam int NST  = (NW + STEPS - 1) / STEPS;
  localparam int PADW = NST * STEPS;

  logic signed [SUM_W-1:0] s [4];
  logic [PADW-1:0] n_a [NST+1][3];
  logic [SUM_W:0]  r_a [NST+1][3];
  logic [SUM_W-1:0] d_a [NST+1];
  logic [2:0]      g_a [NST+1];
  logic            z_a [NST+1];
  logic            v_a [NST+1];
  logic [SUM_W-1:0] wabs;
  logic [SUM_W-1:0] nabs;

  always_comb begin
    for (int c = 0; c < 4; c++) s[c] = sums[c*SUM_W +: SUM_W];
    wabs = s[3][SUM_W-1] ? SUM_W'(-s[3]) : SUM_W'(s[3]);
    nabs = '0;
    for (int l = 0; l < 3; l++) begin
      nabs = s[l][SUM_W-1] ? SUM_W'(-s[l]) : SUM_W'(s[l]);
      n_a[0][l] = PADW'({nabs, {FRAC_BITS{1'b0}}});
      r_a[0][l] = '0;
      g_a[0][l] = s[l][SUM_W-1] ^ s[3][SUM_W-1];
    end
    d_a[0] = wabs;
    z_a[0] = (s[3] == '0);
    v_a[0] = v_in;
  end

  for (genvar g = 0; g < NST; g++) begin : g_div
    ptpd_div_stage #(.NW(PADW), .DW(SUM_W), .STEPS(STEPS)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .v_in(v_a[g]),
      .num_in(n_a[g]), .rem_in(r_a[g]), .den_in(d_a[g]), .neg_in(g_a[g]),
      .wz_in(z_a[g]), .v_out(v_a[g+1]), .num_out(n_a[g+1]),
      .rem_out(r_a[g+1]), .den_out(d_a[g+1]), .neg_out(g_a[g+1]),
      .wz_out(z_a[g+1])
    );
  end

  logic [31:0] q [3];
  logic [2:0]  sat;
  logic [31:0] lim;
  always_comb begin
    lim = '0;
    for (int l = 0; l < 3; l++) begin
      lim    = g_a[NST][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat[l] = (n_a[NST][l] > PADW'(lim));
      q[l]   = sat[l] ? lim : n_a[NST][l][31:0];
      q[l]   = g_a[NST][l] ? 32'(-q[l]) : q[l];
      if (z_a[NST]) q[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_out <= 1'b0;
    else if (adv) v_out <= v_a[NST];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.proj_x  <= q[0];
      res.proj_y  <= q[1];
      res.proj_z  <= q[2];
      res.w_zero  <= z_a[NST];
      res.clipped <= !z_a[NST] && (sat != 3'b000);
    end
  end
endmodule : ptpd_back
`default_nettype wire

// ----- hw/rtl/point_transform_perspective_divide_unit.sv -----
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_unit: 4x4 transform and divide by w
// Transforms (x, y, z, 1) by the configured matrix and projects by w.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | ptpd_pkg::in_item_t
// out_    | output    | out_valid/out_stall| ptpd_pkg::out_item_t
// cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata (64 bit)
//
// One item per cycle sustained while out_stall stays low. The path is a
// product and a sum stage, a queue hop, then ceil((67+FRAC_BITS)/4) divider
// stages (four restoring steps each) plus one output register.
// Synchronous active-low reset empties all pipelines and restores identity.
// The back pipeline freezes while out_stall holds a valid result; the front
// keeps feeding the queue and stalls input only when the queue could fill.
// ----------------------------------------------------------------------------
`default_nettype none
module point_transform_perspective_divide_unit #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ptpd_pkg::IDX_W-1:0]  cfg_idx,
  input  wire logic [ptpd_pkg::REG_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ptpd_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ptpd_pkg::out_item_t              out_data
);
  localparam int SUM_W = 67;
  localparam int QD    = ptpd_pkg::QUEUE_DEPTH;

  logic                 f_valid;
  logic [4*SUM_W-1:0]   f_sums;
  logic                 q_valid;
  logic [4*SUM_W-1:0]   q_data;
  logic [$clog2(QD+1)-1:0] q_count;
  logic                 b_adv;
  logic                 q_rd;

  // Front always advances; accept only when queue has room for all in flight
  // (two front stages plus the new item).
  assign in_stall = (q_count > ($bits(q_count))'(QD - 3));

  ptpd_front #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid && !in_stall), .in_data(in_data),
    .adv(1'b1), .sum_valid(f_valid), .sums(f_sums)
  );

  // Advance the back pipe unless a result sits stalled at the output.
  assign b_adv = !(out_valid && out_stall);
  assign q_rd  = b_adv && q_valid;

  ptpd_queue #(.W(4*SUM_W), .DEPTH(QD)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_sums),
    .rd_en(q_rd), .rd_valid(q_valid), .rd_data(q_data), .count(q_count)
  );

  ptpd_back #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_back (
    .clk(clk), .rst_n(rst_n), .adv(b_adv), .v_in(q_rd), .sums(q_data),
    .v_out(out_valid), .res(out_data)
  );
endmodule : point_transform_perspective_divide_unit
`default_nettype wire
